@@ hdl/tocc_pkg.sv @@
// Package: constants, types and helpers for the tile/object cell compositor.
package tocc_pkg;

	localparam int MAP_TILES_WIDE = 20;
	localparam int MAP_TILES_HIGH = 11;
	localparam int SLOT_COUNT     = 16;
	localparam int TYPE_COUNT     = 64;
	localparam int TYPE_CELLS     = 16;

	localparam int MAP_SIZE   = MAP_TILES_WIDE * MAP_TILES_HIGH;
	localparam int TYPE_BYTES = 2 + 2 * TYPE_CELLS;
	localparam int TYPE_DEPTH = TYPE_COUNT * TYPE_BYTES;
	localparam int DEF_DEPTH  = 2048;
	localparam int OVL_W      = 24;
	localparam int OVL_H      = 3;

	localparam int MAP_AW  = $clog2(MAP_SIZE);
	localparam int DEF_AW  = $clog2(DEF_DEPTH);
	localparam int TYPE_AW = $clog2(TYPE_DEPTH);
	localparam int SLOT_W  = $clog2(SLOT_COUNT);
	localparam int SLOT_ENTRY_W = 22;

	localparam logic [2:0] MODE_MAP   = 3'd0;
	localparam logic [2:0] MODE_DEF   = 3'd1;
	localparam logic [2:0] MODE_SLOT  = 3'd2;
	localparam logic [2:0] MODE_TYPE  = 3'd3;
	localparam logic [2:0] MODE_QUERY = 3'd4;

	localparam logic [1:0] REG_PLAYER  = 2'd0;
	localparam logic [1:0] REG_OVL_ON  = 2'd1;
	localparam logic [1:0] REG_OVL_COL = 2'd2;
	localparam logic [1:0] REG_OVL_ROW = 2'd3;

	localparam logic [3:0] NIB_MASK = 4'hf;

	typedef enum logic [3:0] {
		ST_IDLE, ST_MAP, ST_MAPW, ST_DEFC, ST_DEFK, ST_DEFW,
		ST_SLOT, ST_HDR0, ST_HDR1, ST_CHR, ST_COL, ST_NEXT, ST_DONE
	} state_t;

	typedef struct packed {
		logic [5:0] kind;
		logic [7:0] x;
		logic [7:0] y;
	} slot_entry_t;

	function automatic logic [3:0] gray_of(input logic [3:0] c);
		logic [3:0] g;
		case (c)
			4'd0, 4'd6, 4'd11: g = 4'd0;
			4'd1, 4'd3, 4'd7, 4'd13: g = 4'd12;
			default: g = 4'd11;
		endcase
		return g;
	endfunction

endpackage

@@ hdl/tocc_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read.
module tocc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

@@ hdl/tile_object_cell_compositor_core.sv @@
// Top level: tile/object cell compositor with memory-held map, defs and type store.
// A query looks up the base tile in the map and defs, then walks the slots in order with the
// player slot last, reading headers and cells through the single read port of the type store.
// One item in flight; the next beat is accepted in the cycle after the result is taken.
// After reset the type store clears, one entry per cycle, accepting no items meanwhile; slots
// and registers clear at once.
module tile_object_cell_compositor_core import tocc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [2:0] mode,
	input  logic [7:0] tile_pos,
	input  logic [7:0] tile_number,
	input  logic [2:0] def_byte_index,
	input  logic [7:0] data_byte,
	input  logic [3:0] slot,
	input  logic [5:0] object_type,
	input  logic [7:0] pos_x,
	input  logic [7:0] pos_y,
	input  logic [5:0] type_byte_index,
	input  logic [5:0] cell_x,
	input  logic [4:0] cell_y,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] cell_char,
	output logic [3:0] cell_color,
	output logic [3:0] shown_color,
	input  logic       cfg_we,
	input  logic [1:0] cfg_index,
	input  logic [4:0] cfg_data
);
	state_t state_q, state_d;

	logic [3:0] player_q;
	logic       ovl_on_q;
	logic [4:0] ovl_col_q, ovl_row_q;

	slot_entry_t slots_q [SLOT_COUNT];

	logic              clr_busy_q;
	logic [TYPE_AW-1:0] clr_addr_q;

	logic [5:0] cx_q;
	logic [4:0] cy_q;
	logic [7:0] ch_q;
	logic [3:0] col_q;
	logic [SLOT_W:0] scnt_q;
	logic [SLOT_W-1:0] cur_q;
	logic [3:0] w_q, h_q;
	logic [TYPE_AW-1:0] tbase_q;
	logic [7:0] idx_q;
	logic [7:0] hch_q;
	logic       out_valid_q;
	logic [7:0] och_q;
	logic [3:0] ocol_q, oshown_q;

	logic accept;
	assign in_stall = clr_busy_q || (state_q != ST_IDLE) || out_valid_q;
	assign accept = in_valid && !in_stall;

	// map memory
	logic              map_we;
	logic [MAP_AW-1:0] map_waddr, map_raddr;
	logic [7:0]        map_rdata;
	tocc_ram #(.WIDTH(8), .DEPTH(MAP_SIZE)) u_map (
		.clk, .we(map_we), .waddr(map_waddr), .wdata(tile_number),
		.raddr(map_raddr), .rdata(map_rdata));

	// tile definitions
	logic              def_we;
	logic [DEF_AW-1:0] def_waddr, def_raddr;
	logic [7:0]        def_rdata;
	tocc_ram #(.WIDTH(8), .DEPTH(DEF_DEPTH)) u_def (
		.clk, .we(def_we), .waddr(def_waddr), .wdata(data_byte),
		.raddr(def_raddr), .rdata(def_rdata));

	// type store
	logic               ts_we;
	logic [TYPE_AW-1:0] ts_waddr, ts_raddr;
	logic [7:0]         ts_wdata, ts_rdata;
	tocc_ram #(.WIDTH(8), .DEPTH(TYPE_DEPTH)) u_type (
		.clk, .we(ts_we), .waddr(ts_waddr), .wdata(ts_wdata),
		.raddr(ts_raddr), .rdata(ts_rdata));

	// write decode
	logic [5:0] tc, tr;
	logic [1:0] quad;
	logic       in_map;
	assign tc = {1'b0, cx_q[5:1]};
	assign tr = {2'b0, cy_q[4:1]};
	assign quad = {cy_q[0], cx_q[0]};
	assign in_map = (32'(tc) < MAP_TILES_WIDE) && (32'(tr) < MAP_TILES_HIGH);

	assign map_we = accept && mode == MODE_MAP && 32'(tile_pos) < MAP_SIZE;
	assign map_waddr = MAP_AW'(tile_pos);
	assign map_raddr = MAP_AW'(32'(tr) * MAP_TILES_WIDE + 32'(tc));

	assign def_we = accept && mode == MODE_DEF;
	assign def_waddr = {tile_number, def_byte_index};
	assign def_raddr = (state_q == ST_MAPW) ? {map_rdata, quad, 1'b0}
		: {map_rdata, quad, 1'b1};

	logic ts_user_we;
	assign ts_user_we = accept && mode == MODE_TYPE && 32'(object_type) < TYPE_COUNT
		&& 32'(type_byte_index) < TYPE_BYTES;
	assign ts_we = clr_busy_q || ts_user_we;
	assign ts_waddr = clr_busy_q ? clr_addr_q
		: TYPE_AW'(32'(object_type) * TYPE_BYTES + 32'(type_byte_index));
	assign ts_wdata = clr_busy_q ? 8'd0 : data_byte;

	// slot walk: order 0..N-1 skipping player, then player
	slot_entry_t se;
	logic [SLOT_W-1:0] pick;
	logic last_pass;
	assign last_pass = scnt_q == (SLOT_W+1)'(SLOT_COUNT);
	assign pick = last_pass ? player_q[SLOT_W-1:0] : scnt_q[SLOT_W-1:0];
	assign se = slots_q[cur_q];

	logic [3:0] hx, hy;
	logic signed [9:0] lx, ly;
	logic hdr_ok, cell_in;
	assign hx = ts_rdata[7:4];
	assign hy = ts_rdata[3:0];
	assign hdr_ok = (w_q != 0) && (h_q != 0) && (32'(w_q) * 32'(h_q) <= TYPE_CELLS)
		&& hx < w_q && hy < h_q;
	assign lx = 10'(signed'({4'b0, cx_q})) - (10'(signed'({2'b0, se.x})) - 10'(signed'({6'b0, hx})));
	assign ly = 10'(signed'({5'b0, cy_q})) - (10'(signed'({2'b0, se.y})) - 10'(signed'({6'b0, hy})));
	assign cell_in = !lx[9] && !ly[9] && lx < 10'(signed'({6'b0, w_q}))
		&& ly < 10'(signed'({6'b0, h_q}));

	logic slot_valid;
	assign slot_valid = (se.kind != 0) && (32'(se.kind) < TYPE_COUNT)
		&& !(!last_pass && scnt_q[SLOT_W-1:0] == player_q[SLOT_W-1:0]
			&& 32'(player_q) < SLOT_COUNT);

	always_comb begin
		ts_raddr = tbase_q;
		case (state_q)
			ST_SLOT: ts_raddr = TYPE_AW'(32'(se.kind) * TYPE_BYTES);
			ST_HDR0: ts_raddr = TYPE_AW'(32'(se.kind) * TYPE_BYTES + 1);
			ST_HDR1: ts_raddr = TYPE_AW'(32'(tbase_q) + 2 + 32'(ly) * 32'(w_q) + 32'(lx));
			ST_CHR:  ts_raddr = TYPE_AW'(32'(tbase_q) + 2 + TYPE_CELLS + 32'(idx_q));
			default: ts_raddr = tbase_q;
		endcase
	end

	logic done_slots;
	assign done_slots = last_pass || (32'(player_q) >= SLOT_COUNT
		&& scnt_q == (SLOT_W+1)'(SLOT_COUNT - 1));

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (accept && mode == MODE_QUERY) state_d = ST_MAP;
			ST_MAP:  state_d = ST_MAPW;
			ST_MAPW: state_d = ST_DEFC;
			ST_DEFC: state_d = ST_DEFK;
			ST_DEFK: state_d = ST_SLOT;
			ST_SLOT: state_d = slot_valid ? ST_HDR0 : ST_NEXT;
			ST_HDR0: state_d = ST_HDR1;
			ST_HDR1: state_d = (hdr_ok && cell_in) ? ST_CHR : ST_NEXT;
			ST_CHR:  state_d = (ts_rdata != 0) ? ST_COL : ST_NEXT;
			ST_COL:  state_d = ST_NEXT;
			ST_NEXT: state_d = done_slots ? ST_DONE : ST_SLOT;
			ST_DONE: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	logic in_ovl;
	assign in_ovl = ovl_on_q && cx_q >= 6'(ovl_col_q) && 7'(cx_q) < 7'(ovl_col_q) + 7'(OVL_W)
		&& cy_q >= ovl_row_q && 6'(cy_q) < 6'(ovl_row_q) + 6'(OVL_H);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			player_q <= '0;
			ovl_on_q <= 1'b0;
			ovl_col_q <= '0;
			ovl_row_q <= '0;
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < SLOT_COUNT; i++) slots_q[i] <= '0;
		end else begin
			state_q <= state_d;
			if (clr_busy_q) begin
				clr_addr_q <= clr_addr_q + 1'b1;
				if (32'(clr_addr_q) == TYPE_DEPTH - 1) clr_busy_q <= 1'b0;
			end
			if (cfg_we) begin
				case (cfg_index)
					REG_PLAYER:  player_q <= cfg_data[3:0];
					REG_OVL_ON:  ovl_on_q <= cfg_data[0];
					REG_OVL_COL: ovl_col_q <= cfg_data;
					REG_OVL_ROW: ovl_row_q <= cfg_data;
					default: ;
				endcase
			end
			if (accept && mode == MODE_SLOT && 32'(slot) < SLOT_COUNT)
				slots_q[slot[SLOT_W-1:0]] <= '{kind: object_type, x: pos_x, y: pos_y};
			if (state_q == ST_DONE) out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				cx_q <= cell_x;
				cy_q <= cell_y;
			end
			ST_DEFC: begin
				ch_q <= in_map ? def_rdata : 8'd0;
				scnt_q <= '0;
				cur_q <= '0;
			end
			ST_DEFK: begin
				col_q <= in_map ? def_rdata[3:0] : 4'd0;
				cur_q <= pick;
			end
			ST_SLOT: tbase_q <= TYPE_AW'(32'(se.kind) * TYPE_BYTES);
			ST_HDR0: begin
				w_q <= ts_rdata[7:4];
				h_q <= ts_rdata[3:0];
			end
			ST_HDR1: idx_q <= 8'(32'(ly) * 32'(w_q) + 32'(lx));
			ST_CHR:  hch_q <= ts_rdata;
			ST_COL: begin
				ch_q <= hch_q;
				col_q <= ts_rdata[3:0] & NIB_MASK;
			end
			ST_NEXT: begin
				scnt_q <= scnt_q + 1'b1;
				cur_q <= ((scnt_q + 1'b1) == (SLOT_W+1)'(SLOT_COUNT))
					? player_q[SLOT_W-1:0] : SLOT_W'(scnt_q + 1'b1);
			end
			ST_DONE: begin
				och_q <= ch_q;
				ocol_q <= col_q;
				oshown_q <= in_ovl ? gray_of(col_q) : col_q;
			end
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;
	assign cell_char = och_q;
	assign cell_color = ocol_q;
	assign shown_color = oshown_q;
endmodule

@@ hdl/tocc_checker.sv @@
// Port-level checker for the compositor, bound to the top level.
module tocc_checker import tocc_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic [2:0] mode,
	input logic       out_valid,
	input logic       out_stall,
	input logic [7:0] cell_char,
	input logic [3:0] cell_color,
	input logic [3:0] shown_color
);
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(cell_char) && $stable(cell_color))
		else $error("stalled result changed");
	a_busy_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("input taken while result pending");
	a_accept_stall: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && mode == MODE_QUERY |=> in_stall)
		else $error("beat accepted right after a query");
	a_shown: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (cell_color == 4'd0) |-> (shown_color == 4'd0))
		else $error("color zero shown non-zero");
endmodule

bind tile_object_cell_compositor_core tocc_checker u_tocc_checker (.*);
